// File: rtl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants for the sorted key table with binary-search
// lookup.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int KEY_W               = 64;
    localparam int INDEX_W             = 10;
    localparam int COUNT_W             = 11;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [INDEX_W-1:0] entry_index;
        logic [KEY_W-1:0]   hash_value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic hit;
        logic empty;
    } step_status_t;

endpackage

// File: rtl/sht_key_ram.sv
// ----------------------------------------------------------------------------
// sht_key_ram
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sht_key_ram #(
    parameter int DEPTH  = sht_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = sht_pkg::KEY_W
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sht_probe_step.sv
// ----------------------------------------------------------------------------
// sht_probe_step
// One binary-search step: compare the probed key, narrow the window and
// pick the next probe position.
// ----------------------------------------------------------------------------
module sht_probe_step #(
    parameter int TABLE_DEPTH = sht_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic [sht_pkg::KEY_W-1:0] key,
    input  logic [sht_pkg::KEY_W-1:0] probe_key,
    input  logic [CNT_W-1:0]          lo,
    input  logic [CNT_W-1:0]          hi,
    input  logic [ADDR_W-1:0]         mid,
    output sht_pkg::step_status_t     status,
    output logic [CNT_W-1:0]          lo_next,
    output logic [CNT_W-1:0]          hi_next,
    output logic [ADDR_W-1:0]         mid_next
);

    import sht_pkg::*;

    logic             eq;
    logic             gt;
    logic [CNT_W-1:0] mid_ext;
    logic [CNT_W-1:0] span;

    always_comb
    begin
        eq      = (probe_key == key);
        gt      = (probe_key > key);
        mid_ext = CNT_W'(mid);
        lo_next = lo;
        hi_next = hi;
        if (!eq)
        begin
            if (gt)
            begin
                hi_next = mid_ext;
            end
            else
            begin
                lo_next = mid_ext + CNT_W'(1);
            end
        end
        span         = hi_next - CNT_W'(1) - lo_next;
        mid_next     = ADDR_W'(lo_next + (span >> 1));
        status.hit   = eq;
        status.empty = !eq && (lo_next >= hi_next);
    end

endmodule

// File: rtl/sorted_hash_table_lookup_top.sv
// ----------------------------------------------------------------------------
// sorted_hash_table_lookup_top
// Sorted 64-bit key table with iterative binary-search lookup.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): a write transaction stores
// hash_value at entry_index and completes in the accepting cycle; writes at
// or beyond TABLE_DEPTH are dropped. A lookup transaction searches the first
// entry_count keys (clamped to TABLE_DEPTH) and yields one result on the
// output channel (out_valid / out_stall / out_data).
// Lookup: at most ceil(log2(count+1)) probes, then the result hand-off
// through ST_FINISH and the output register; an empty window goes straight
// to ST_FINISH without a search step. The first key read is issued at the
// accepting edge, and the single comparator with its registered key-memory
// read port sets the one-probe-per-cycle pace.
// in_stall is high for the whole lookup and drops in the same cycle as the
// result is presented; writes are taken back to back.
// A stalled result holds in the output register; a finished lookup waits
// until that register is free. Reset clears control state and entry_count;
// the key memory is not cleared and must be loaded in ascending order
// before any lookup reaches its entries. cfg_wr_en writes entry_count.
// ----------------------------------------------------------------------------
module sorted_hash_table_lookup_top #(
    parameter int TABLE_DEPTH = sht_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  sht_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output sht_pkg::out_item_t          out_data,
    input  logic                        cfg_wr_en,
    input  logic [sht_pkg::COUNT_W-1:0] cfg_wr_data
);

    import sht_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_CW = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;
    localparam int CNT_CW = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_next;
    logic [CNT_W-1:0]     lo_reg;
    logic [CNT_W-1:0]     lo_next;
    logic [CNT_W-1:0]     hi_reg;
    logic [CNT_W-1:0]     hi_next;
    logic [ADDR_W-1:0]    mid_reg;
    logic [ADDR_W-1:0]    mid_next;
    logic                 res_found_reg;
    logic                 res_found_next;
    logic [INDEX_W-1:0]   res_index_reg;
    logic [INDEX_W-1:0]   res_index_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_data_reg;
    out_item_t            out_data_next;

    logic                 in_accept;
    logic                 start_lookup;
    logic                 wr_en;
    logic [CNT_W-1:0]     hi_start;
    logic [CNT_W-1:0]     start_span;
    logic [ADDR_W-1:0]    mid_start;
    logic [ADDR_W-1:0]    rd_addr;
    logic [KEY_W-1:0]     probe_key;
    logic                 out_free;
    logic                 out_load;
    step_status_t         step_status;
    logic [CNT_W-1:0]     step_lo;
    logic [CNT_W-1:0]     step_hi;
    logic [ADDR_W-1:0]    step_mid;

    sht_key_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (KEY_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(in_data.entry_index)),
        .wr_data (in_data.hash_value),
        .rd_addr (rd_addr),
        .rd_data (probe_key)
    );

    sht_probe_step #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_probe_step (
        .key       (key_reg),
        .probe_key (probe_key),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .mid       (mid_reg),
        .status    (step_status),
        .lo_next   (step_lo),
        .hi_next   (step_hi),
        .mid_next  (step_mid)
    );

    // window setup for a new lookup
    always_comb
    begin
        if (CNT_CW'(count_reg) > CNT_CW'(TABLE_DEPTH))
        begin
            hi_start = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            hi_start = CNT_W'(count_reg);
        end
        start_span = hi_start - CNT_W'(1);
        mid_start  = ADDR_W'(start_span >> 1);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_lookup)
                begin
                    state_next = (hi_start == '0) ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (step_status.hit || step_status.empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        rd_addr  = step_mid;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                rd_addr  = mid_start;
            end
            ST_SEARCH:
            begin
                rd_addr = step_mid;
            end
            ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign in_accept    = in_valid && !in_stall;
    assign start_lookup = in_accept && (in_data.req_type == REQ_LOOKUP);
    assign wr_en        = in_accept && (in_data.req_type == REQ_WRITE)
                          && (IDX_CW'(in_data.entry_index) < IDX_CW'(TABLE_DEPTH));
    assign out_free     = !out_valid_reg || !out_stall;

    always_comb
    begin
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        if (start_lookup)
        begin
            key_next       = in_data.hash_value;
            lo_next        = '0;
            hi_next        = hi_start;
            mid_next       = mid_start;
            res_found_next = 1'b0;
            res_index_next = '0;
        end
        else if (state_reg == ST_SEARCH)
        begin
            lo_next  = step_lo;
            hi_next  = step_hi;
            mid_next = step_mid;
            if (step_status.hit)
            begin
                res_found_next = 1'b1;
                res_index_next = INDEX_W'(mid_reg);
            end
        end
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.found       = res_found_reg;
            out_data_next.match_index = res_index_reg;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result presented without a finished lookup");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg < hi_reg))
        else $error("search running on an empty window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |->
            ((CNT_W'(mid_reg) >= lo_reg) && (CNT_W'(mid_reg) < hi_reg)))
        else $error("probe position outside the search window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (hi_reg <= CNT_W'(TABLE_DEPTH)))
        else $error("search window beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |-> (out_data.match_index == '0))
        else $error("miss result carries a nonzero index");

endmodule

// File: test/sht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sht_checker
// Watches the input, output and register ports of the sorted key table,
// mirrors the key memory and entry_count, predicts each lookup answer with
// the same probe order as the block (middle of [lo, hi), rounding toward lo)
// and compares every output transaction with the oldest pending answer.
// ----------------------------------------------------------------------------
module sht_checker #(
    parameter int TABLE_DEPTH = sht_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  sht_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  sht_pkg::out_item_t          out_data,
    input  logic                        cfg_wr_en,
    input  logic [sht_pkg::COUNT_W-1:0] cfg_wr_data,
    output int                          fail_count,
    output int                          pending_lookups
);
    import sht_pkg::*;

    logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0] key_count = '0;
    out_item_t          answers_due [$];
    int                 mismatches = 0;

    function automatic out_item_t search_keys(logic [KEY_W-1:0] key);
        out_item_t answer;
        int        lo;
        int        hi;
        int        mid;
        answer = '0;
        lo     = 0;
        hi     = (int'(key_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(key_count);
        while (lo < hi && !answer.found)
        begin
            mid = lo + (hi - 1 - lo) / 2;
            if (key_mem[mid] == key)
            begin
                answer.found       = 1'b1;
                answer.match_index = INDEX_W'(mid);
            end
            else if (key_mem[mid] > key)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            key_count = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                key_mem[i] = '0;
            end
            answers_due.delete();
            pending_lookups <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                key_count = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.req_type == REQ_WRITE)
                begin
                    if (int'(in_data.entry_index) < TABLE_DEPTH)
                    begin
                        key_mem[in_data.entry_index] = in_data.hash_value;
                    end
                end
                else
                begin
                    answers_due.push_back(search_keys(in_data.hash_value));
                end
            end
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: unexpected result found=%0b index=%0d", $realtime,
                                 out_data.found, out_data.match_index);
                    end
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (out_data.found !== want.found
                        || out_data.match_index !== want.match_index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"%0t: mismatch expected found=%0b index=%0d,",
                                      " got found=%0b index=%0d"},
                                     $realtime, want.found, want.match_index,
                                     out_data.found, out_data.match_index);
                        end
                    end
                end
            end
            pending_lookups <= answers_due.size();
        end
        fail_count <= mismatches;
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the sorted key table: directed lookups on an empty table, a
// full ascending table load, clamped and edge counts and duplicate keys, then
// random phases of table rewrites, stray writes, count changes and lookups
// with random idling on both channels. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import sht_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    in_item_t           in_data     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    out_item_t          out_data;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    int                 fail_count;
    int                 pending_lookups;

    int                 idle_pct    = 29;
    int                 sent_items  = 0;
    logic [COUNT_W-1:0] live_count  = '0;
    logic [KEY_W-1:0]   shadow_keys [DEPTH];

    sorted_hash_table_lookup_top #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    sht_checker #(
        .TABLE_DEPTH(DEPTH)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .pending_lookups(pending_lookups)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic drive_item(input in_item_t item);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic put_key(input int idx, input logic [KEY_W-1:0] key);
        in_item_t item;
        item.req_type    = REQ_WRITE;
        item.entry_index = INDEX_W'(idx);
        item.hash_value  = key;
        shadow_keys[idx] = key;
        drive_item(item);
    endtask

    task automatic find_key(input logic [KEY_W-1:0] key);
        in_item_t item;
        item.req_type    = REQ_LOOKUP;
        item.entry_index = INDEX_W'($urandom);
        item.hash_value  = key;
        drive_item(item);
    endtask

    // hold off until the last lookup has answered and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_lookups != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        live_count   = COUNT_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ascending keys in entries 0..n-1, optionally with repeated neighbors
    task automatic load_ordered(input int n, input bit with_repeats);
        int               span;
        logic [9:0]       lead;
        logic [KEY_W-1:0] key;
        span = DEPTH / n;
        for (int i = 0; i < n; i++)
        begin
            lead = 10'(i * span + $urandom_range(0, span - 1));
            key  = {lead, 22'($urandom), 32'($urandom)};
            if (with_repeats && i > 0 && $urandom_range(0, 3) == 0)
            begin
                key = shadow_keys[i - 1];
            end
            put_key(i, key);
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int               span;
        int               roll;
        logic [KEY_W-1:0] key;
        span = (int'(live_count) > DEPTH) ? DEPTH : int'(live_count);
        roll = $urandom_range(0, 99);
        key  = {$urandom, $urandom};
        if (span > 0 && roll < 50)
        begin
            key = shadow_keys[$urandom_range(0, span - 1)];
        end
        else if (span > 0 && roll < 70)
        begin
            key = shadow_keys[$urandom_range(0, span - 1)];
            key = roll[0] ? key + 64'd1 : key - 64'd1;
        end
        else if (roll < 80)
        begin
            key = roll[0] ? '1 : '0;
        end
        return key;
    endfunction

    initial
    begin
        int               phase;
        int               roll;
        int               n;
        int               count;
        logic [KEY_W-1:0] dup_key;

        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_keys[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table
        find_key('0);
        find_key('1);
        load_ordered(DEPTH, 1'b0);

        settle();
        set_count((1 << COUNT_W) - 1);
        find_key(shadow_keys[0]);
        find_key(shadow_keys[DEPTH - 1]);
        find_key(shadow_keys[DEPTH / 2 - 1]);
        find_key('0);
        find_key('1);
        find_key(shadow_keys[300] + 64'd1);

        settle();
        set_count(DEPTH);
        find_key(shadow_keys[DEPTH - 1]);
        find_key(shadow_keys[DEPTH - 1] + 64'd1);

        settle();
        set_count(1);
        find_key(shadow_keys[0]);
        find_key(shadow_keys[1]);

        dup_key = {$urandom, $urandom};
        for (int i = 0; i < 4; i++)
        begin
            put_key(i, dup_key);
        end
        settle();
        set_count(4);
        find_key(dup_key);

        phase = 0;
        while (sent_items < 1350)
        begin
            idle_pct <= (phase >= 3 && phase < 7) ? 0 : 29;
            roll  = $urandom_range(0, 99);
            count = int'(live_count);
            if (roll < 55)
            begin
                roll = $urandom_range(0, 99);
                n = (roll < 75) ? $urandom_range(1, 24)
                  : (roll < 97) ? $urandom_range(25, 64)
                  : $urandom_range(65, 160);
                load_ordered(n, $urandom_range(0, 3) == 0);
                roll  = $urandom_range(0, 99);
                count = (roll < 80) ? n
                      : (roll < 95) ? n + $urandom_range(1, 8)
                      : 0;
            end
            else if (roll < 65)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    put_key($urandom_range(0, DEPTH - 1), {$urandom, $urandom});
                end
            end
            else
            begin
                roll  = $urandom_range(0, 99);
                count = (roll < 10) ? 0
                      : (roll < 25) ? DEPTH
                      : (roll < 35) ? (1 << COUNT_W) - 1
                      : (roll < 45) ? $urandom_range(DEPTH + 1, (1 << COUNT_W) - 1)
                      : $urandom_range(1, DEPTH);
            end
            settle();
            set_count(count);
            repeat ($urandom_range(4, 24))
            begin
                find_key(pick_key());
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending_lookups == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sht_pkg.sv
rtl/sht_key_ram.sv
rtl/sht_probe_step.sv
rtl/sorted_hash_table_lookup_top.sv
test/sht_checker.sv
test/tb_top.sv
